### rtl/core/mqfb_pkg.sv
// Package with sizes, codes and types shared by the multi-queue deque core.
package mqfb_pkg;

  localparam int NUM_QUEUES = 20;
  localparam int DEPTH      = 8;

  localparam int QIDX_W  = 5;
  localparam int TAG_W   = 16;
  localparam int CFG_W   = 4;
  localparam int ENTRY_W = TAG_W + 1;

  localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HEAD_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ADDR_W = $clog2(NUM_QUEUES * DEPTH);

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(5);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED  = 3'd0,
    ST_FULL   = 3'd1,
    ST_SERVED = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BADIDX = 3'd4
  } status_e;

endpackage

### rtl/core/multi_queue_front_back_insert_core.sv
// Bank of bounded double-ended queues with front insert for urgent entries.
// An add, or a serve that pops nothing, gives its result in the cycle after
// acceptance; a serve that pops an entry reads it into rdata_q, enters S_READ
// and then registers its result. Adds sustain one beat per cycle while the
// output beat is free or being taken; a popping serve holds off input in S_READ.
// Reset clears all head pointers and counts and sets the capacity to five; the entry
// memory is not cleared, since only written entries are ever read.
module multi_queue_front_back_insert_core
  import mqfb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  input  logic [QIDX_W-1:0] in_queue_index_i,
  input  logic              in_urgent_i,
  input  logic [TAG_W-1:0]  in_entry_tag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_status_o,
  output logic [TAG_W-1:0]  out_served_tag_o,
  output logic              out_served_urgent_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    cap_q;
  logic [HEAD_W-1:0]   head_q [NUM_QUEUES];
  logic [CNT_W-1:0]    cnt_q  [NUM_QUEUES];
  logic                out_valid_q;
  logic                out_valid_d;
  status_e             status_q;
  logic [TAG_W-1:0]    tag_q;
  logic                urg_q;

  logic [ENTRY_W-1:0]  mem [NUM_QUEUES * DEPTH];
  logic [ENTRY_W-1:0]  rdata_q;

  logic                in_fire;
  logic                bad_idx;
  logic [QSEL_W-1:0]   qsel;
  logic [HEAD_W-1:0]   head_cur;
  logic [CNT_W-1:0]    cnt_cur;
  logic                full;
  logic                empty;
  logic [HEAD_W-1:0]   head_prev;
  logic [HEAD_W-1:0]   head_next;
  logic [HEAD_W:0]     tail_sum;
  logic [HEAD_W-1:0]   tail_slot;
  logic [HEAD_W-1:0]   slot;
  logic [ADDR_W-1:0]   addr;
  logic                mem_we;
  logic                mem_re;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    bad_idx   = ({1'b0, in_queue_index_i} >= (QIDX_W + 1)'(NUM_QUEUES));
    qsel      = QSEL_W'(in_queue_index_i);
    head_cur  = bad_idx ? '0 : head_q[qsel];
    cnt_cur   = bad_idx ? '0 : cnt_q[qsel];
    full      = (CMP_W'(cnt_cur) >= CMP_W'(cap_q)) || (cnt_cur == CNT_W'(DEPTH));
    empty     = (cnt_cur == '0);
    head_prev = (head_cur == '0) ? HEAD_W'(DEPTH - 1) : head_cur - 1'b1;
    head_next = (head_cur == HEAD_W'(DEPTH - 1)) ? '0 : head_cur + 1'b1;
    tail_sum  = (HEAD_W + 1)'(head_cur) + (HEAD_W + 1)'(cnt_cur);
    tail_slot = (tail_sum >= (HEAD_W + 1)'(DEPTH)) ?
                HEAD_W'(tail_sum - (HEAD_W + 1)'(DEPTH)) : HEAD_W'(tail_sum);
    if (in_op_i == OP_SERVE) begin
      slot = head_cur;
    end else if (in_urgent_i) begin
      slot = head_prev;
    end else begin
      slot = tail_slot;
    end
    addr   = ADDR_W'(qsel * DEPTH) + ADDR_W'(slot);
    mem_we = in_fire && !bad_idx && (in_op_i == OP_ADD) && !full;
    mem_re = in_fire && !bad_idx && (in_op_i == OP_SERVE) && !empty;
    out_valid_d = out_valid_q && !out_ready_i;
    if ((state_q == S_READ) || (in_fire && !mem_re)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= {in_urgent_i, in_entry_tag_i};
    end
    if (mem_re) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
      status_q    <= ST_ADDED;
      tag_q       <= '0;
      urg_q       <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            tag_q <= '0;
            urg_q <= 1'b0;
            if (bad_idx) begin
              status_q <= ST_BADIDX;
            end else if (in_op_i == OP_ADD) begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                status_q    <= ST_ADDED;
                cnt_q[qsel] <= cnt_cur + 1'b1;
                if (in_urgent_i) begin
                  head_q[qsel] <= head_prev;
                end
              end
            end else if (empty) begin
              status_q <= ST_EMPTY;
            end else begin
              head_q[qsel] <= head_next;
              cnt_q[qsel]  <= cnt_cur - 1'b1;
              state_q      <= S_READ;
            end
          end
        end
        S_READ: begin
          status_q <= ST_SERVED;
          tag_q    <= rdata_q[TAG_W-1:0];
          urg_q    <= rdata_q[TAG_W];
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = status_q;
  assign out_served_tag_o    = tag_q;
  assign out_served_urgent_o = urg_q;

  a_read_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !in_ready_o)
    else $error("input accepted while a memory read is pending");

  a_read_gives_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (out_valid_o && (out_status_o == ST_SERVED)))
    else $error("pending read did not produce a served beat");

  a_unserved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o != ST_SERVED)) |->
      ((out_served_tag_o == '0) && !out_served_urgent_o))
    else $error("served fields nonzero on a beat that served nothing");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !bad_idx) |-> (cnt_cur <= CNT_W'(DEPTH)))
    else $error("queue count exceeds depth");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (cnt_q[$past(qsel)] == $past(cnt_cur) + 1'b1))
    else $error("accepted add did not raise the queue count");

endmodule

### test/multi_queue_front_back_insert_core_tb.sv
// Self-checking testbench for the multi-queue deque core with a scoreboard class and stall patterns.
import mqfb_pkg::*;

typedef struct packed {
  status_e          status;
  logic [TAG_W-1:0] tag;
  logic             urgent;
} outcome_t;

class deque_scoreboard;
  logic [ENTRY_W-1:0] slots [NUM_QUEUES][DEPTH];
  logic [HEAD_W-1:0]  head [NUM_QUEUES];
  logic [CNT_W-1:0]   count [NUM_QUEUES];
  logic [CFG_W-1:0]   capacity;
  outcome_t           awaited[$];
  int                 errors;
  int                 beats;
  int                 results;
  int                 seen [5];

  function new();
    foreach (head[i]) begin
      head[i] = '0;
      count[i] = '0;
    end
    foreach (seen[i]) begin
      seen[i] = 0;
    end
    capacity = CAP_RESET;
    errors = 0;
    beats = 0;
    results = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void note_beat(logic op, logic [QIDX_W-1:0] qi, logic urg, logic [TAG_W-1:0] tag);
    outcome_t o;
    int lim;
    int slot;
    o.status = ST_ADDED;
    o.tag = '0;
    o.urgent = 1'b0;
    beats++;
    if (qi >= NUM_QUEUES) begin
      o.status = ST_BADIDX;
    end else if (op == OP_ADD) begin
      lim = (capacity > DEPTH) ? DEPTH : int'(capacity);
      if (count[qi] >= lim) begin
        o.status = ST_FULL;
      end else begin
        if (urg) begin
          head[qi] = HEAD_W'((int'(head[qi]) + DEPTH - 1) % DEPTH);
          slot = int'(head[qi]);
        end else begin
          slot = (int'(head[qi]) + int'(count[qi])) % DEPTH;
        end
        slots[qi][slot] = {urg, tag};
        count[qi] = count[qi] + 1'b1;
      end
    end else if (count[qi] == 0) begin
      o.status = ST_EMPTY;
    end else begin
      o.status = ST_SERVED;
      {o.urgent, o.tag} = slots[qi][head[qi]];
      head[qi] = HEAD_W'((int'(head[qi]) + 1) % DEPTH);
      count[qi] = count[qi] - 1'b1;
    end
    seen[int'(o.status)]++;
    awaited.insert(awaited.size(), o);
  endfunction

  task report_mismatch(string what);
    $display("Mismatch on result beat %0d: %s", results, what);
    errors++;
  endtask

  task check_result(logic [2:0] st, logic [TAG_W-1:0] tag, logic urg);
    outcome_t o;
    results++;
    if (awaited.size() == 0) begin
      report_mismatch("result beat with no outcome awaited");
      return;
    end
    o = awaited.pop_front();
    if (st !== o.status) begin
      report_mismatch($sformatf("status %0d, expected %0d", st, o.status));
    end
    if (tag !== o.tag) begin
      report_mismatch($sformatf("served tag %h, expected %h", tag, o.tag));
    end
    if (urg !== o.urgent) begin
      report_mismatch($sformatf("served urgent %b, expected %b", urg, o.urgent));
    end
  endtask
endclass

module multi_queue_front_back_insert_core_tb;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              in_op_i;
  logic [QIDX_W-1:0] in_queue_index_i;
  logic              in_urgent_i;
  logic [TAG_W-1:0]  in_entry_tag_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [2:0]        out_status_o;
  logic [TAG_W-1:0]  out_served_tag_o;
  logic              out_served_urgent_o;

  deque_scoreboard sb = new();
  int              cycle_count = 0;
  int              config_writes = 0;
  int              phase_cap [PHASES] = '{8, 2, 15, 0, 1, 3, 9, 5};
  int              phase_add [PHASES] = '{75, 40, 65, 50, 55, 50, 60, 50};

  multi_queue_front_back_insert_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_op_i             (in_op_i),
    .in_queue_index_i    (in_queue_index_i),
    .in_urgent_i         (in_urgent_i),
    .in_entry_tag_i      (in_entry_tag_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_status_o        (out_status_o),
    .out_served_tag_o    (out_served_tag_o),
    .out_served_urgent_o (out_served_urgent_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_beat(logic op, logic [QIDX_W-1:0] qi, logic urg, logic [TAG_W-1:0] tag);
    in_valid_i       <= 1'b1;
    in_op_i          <= op;
    in_queue_index_i <= qi;
    in_urgent_i      <= urg;
    in_entry_tag_i   <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(op, qi, urg, tag);
  endtask

  task automatic idle(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(int value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.capacity = CFG_W'(value);
    config_writes++;
  endtask

  task automatic run_phase(int n, int add_pct);
    int                burst;
    int                gap;
    int                r;
    logic              op;
    logic [QIDX_W-1:0] qi;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) idle(gap);
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        qi = QIDX_W'($urandom_range(NUM_QUEUES, 2**QIDX_W - 1));
      end else if (r < 60) begin
        qi = QIDX_W'($urandom_range(0, 3));
      end else begin
        qi = QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
      end
      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_SERVE;
      send_beat(op, qi, 1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  initial begin
    int mode;
    int left;
    int hold_left;
    bit held;
    mode = 0;
    left = 0;
    hold_left = 0;
    held = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_status_o, out_served_tag_o, out_served_urgent_o);
      end
      if (!held && sb.beats >= 700) begin
        held = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(8, 40);
        end
        left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    in_op_i          <= OP_ADD;
    in_queue_index_i <= '0;
    in_urgent_i      <= 1'b0;
    in_entry_tag_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OP_SERVE, 0, 1'b0, 16'h0000);
    send_beat(OP_ADD, 20, 1'b0, 16'h1111);
    send_beat(OP_SERVE, 31, 1'b1, 16'hFFFF);
    send_beat(OP_ADD, 0, 1'b0, 16'h0000);
    send_beat(OP_ADD, 0, 1'b1, 16'hFFFF);
    send_beat(OP_ADD, 0, 1'b0, 16'h1234);
    send_beat(OP_ADD, 0, 1'b1, 16'hA5A5);
    send_beat(OP_ADD, 0, 1'b0, 16'h5A5A);
    send_beat(OP_ADD, 0, 1'b1, 16'h7777);
    send_beat(OP_ADD, 0, 1'b0, 16'h8888);
    repeat (5) send_beat(OP_SERVE, 0, 1'b0, 16'h0000);
    send_beat(OP_SERVE, 0, 1'b0, 16'h0000);
    send_beat(OP_ADD, 19, 1'b1, 16'hFFFF);
    send_beat(OP_ADD, 19, 1'b0, 16'h8001);
    send_beat(OP_SERVE, 19, 1'b0, 16'h0000);
    send_beat(OP_SERVE, 19, 1'b1, 16'hFFFF);
    send_beat(OP_ADD, 31, 1'b1, 16'hFFFF);
    send_beat(OP_SERVE, 20, 1'b0, 16'h0000);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      run_phase(220, phase_add[p]);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d beats over %0d capacity settings, from zero through fifteen.",
             sb.beats, config_writes);
    $display("Outcomes: %0d added, %0d full, %0d served, %0d empty, %0d bad index, %0d errors.",
             sb.seen[ST_ADDED], sb.seen[ST_FULL], sb.seen[ST_SERVED], sb.seen[ST_EMPTY],
             sb.seen[ST_BADIDX], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
